// ===== rtl/core/vrts_pkg.sv =====
package vrts_pkg;

  localparam int unsigned MaxTasksDef   = 16;
  localparam logic [4:0]  PrioMax       = 5'd31;
  localparam logic [4:0]  PrioDefault   = 5'd16;
  localparam logic [5:0]  WeightBase    = 6'd40;
  localparam logic [5:0]  RtDivisor     = 6'd4;
  localparam logic [10:0] RtBonus       = 11'd1000;
  localparam logic [31:0] QuantumDef    = 32'd10;
  localparam logic [31:0] FirstNewId    = 32'd2;

  typedef enum logic [3:0] {
    KIND_TICK    = 4'd0,
    KIND_YIELD   = 4'd1,
    KIND_YIELD_P = 4'd2,
    KIND_CREATE  = 4'd3,
    KIND_KILL    = 4'd4,
    KIND_EXIT    = 4'd5,
    KIND_PRIO    = 4'd6,
    KIND_RT      = 4'd7,
    KIND_BOOST   = 4'd8,
    KIND_RESTORE = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    RS_READY   = 2'd0,
    RS_RUNNING = 2'd1,
    RS_DEAD    = 2'd2
  } run_state_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_PREP, ST_PICK, ST_FIN, ST_CMP, ST_CEND, ST_FIND,
    ST_APPLY, ST_DONE
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_PICK, OP_FIN, OP_CMP, OP_CEND, OP_FIND, OP_APPLY
  } dp_op_e;

  typedef struct packed {
    logic       resched;
    logic       hit;
    logic [3:0] kind;
  } dp_status_t;

  function automatic logic [4:0] clamp_prio(input logic signed [6:0] raw);
    logic [4:0] v;
    v = raw[4:0];
    if (raw[6]) begin
      v = '0;
    end else if (raw[5]) begin
      v = PrioMax;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/vrts_ctrl.sv =====
module vrts_ctrl
  import vrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasksDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  dp_status_t                       status_i,
  input  logic [$clog2(MAX_TASKS+1)-1:0]   count_i,
  output dp_op_e                           op_o,
  output logic [$clog2(MAX_TASKS)-1:0]     idx_o,
  output logic                             busy_o,
  output logic                             done_o
);

  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned IW = $clog2(MAX_TASKS);

  ctrl_state_e     state_q, state_d;
  logic [CW-1:0]   k_q, k_d;
  logic            last;

  assign last = ((k_q + CW'(1)) == count_i);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        k_d = '0;
        case (status_i.kind)
          KIND_YIELD, KIND_EXIT: state_d = ST_PREP;
          KIND_YIELD_P: state_d = status_i.resched ? ST_PREP : ST_APPLY;
          KIND_KILL, KIND_PRIO, KIND_RT, KIND_BOOST, KIND_RESTORE: state_d = ST_FIND;
          default: state_d = ST_APPLY;
        endcase
      end
      ST_PREP: state_d = ST_PICK;
      ST_PICK: begin
        k_d = k_q + CW'(1);
        if (last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        k_d     = '0;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        k_d = k_q + CW'(1);
        if (last) begin
          state_d = ST_CEND;
        end
      end
      ST_CEND: state_d = ST_DONE;
      ST_FIND: begin
        k_d = k_q + CW'(1);
        if (status_i.hit || last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_o   = OP_NONE;
    busy_o = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
    idx_o  = k_q[IW-1:0];
    unique case (state_q)
      ST_IDLE:  op_o = start_i ? OP_LOAD : OP_NONE;
      ST_PREP:  op_o = OP_PREP;
      ST_PICK:  op_o = OP_PICK;
      ST_FIN:   op_o = OP_FIN;
      ST_CMP:   op_o = OP_CMP;
      ST_CEND:  op_o = OP_CEND;
      ST_FIND:  op_o = OP_FIND;
      ST_APPLY: op_o = OP_APPLY;
      default:  op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

// ===== rtl/core/vrts_dp.sv =====
module vrts_dp
  import vrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasksDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dp_op_e                          op_i,
  input  logic [$clog2(MAX_TASKS)-1:0]    idx_i,
  output dp_status_t                      status_o,
  output logic [$clog2(MAX_TASKS+1)-1:0]  count_o,
  input  logic [3:0]                      kind_i,
  input  logic [31:0]                     task_id_i,
  input  logic signed [6:0]               priority_req_i,
  input  logic                            realtime_req_i,
  input  logic                            cfg_we_i,
  input  logic [31:0]                     cfg_data_i,
  output logic [31:0]                     current_id_o,
  output logic [31:0]                     result_id_o,
  output logic                            ok_o,
  output logic                            switched_o,
  output logic                            resched_pending_o,
  output logic [4:0]                      target_priority_o,
  output logic [63:0]                     tick_total_o,
  output logic [63:0]                     switch_total_o
);

  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned IW = $clog2(MAX_TASKS);

  logic [MAX_TASKS-1:0] used_q, rt_q, boost_q;
  logic [31:0]          tid_q   [MAX_TASKS];
  run_state_e           st_q    [MAX_TASKS];
  logic [4:0]           base_q  [MAX_TASKS];
  logic [4:0]           eff_q   [MAX_TASKS];
  logic [31:0]          ticks_q [MAX_TASKS];
  logic [63:0]          vr_q    [MAX_TASKS];

  logic [3:0]    kind_q;
  logic [31:0]   tid_in_q;
  logic [4:0]    req_q;
  logic          rtreq_q;
  logic [IW-1:0] run_q, cur_q, scan_q, best_q, t_q, nrun_q, ncur_q;
  logic          bestv_q, ncurv_q, found_q;
  logic [63:0]   bestvr_q;
  logic [10:0]   bestsc_q;
  logic [CW-1:0] n_q, w_q;
  logic [31:0]   nid_q, quant_q;
  logic [63:0]   tick_q, sw_q;
  logic          flag_q, ok_q, moved_q;
  logic [4:0]    tprio_q;
  logic [31:0]   newid_q;

  logic [IW-1:0] scan_next, start_pos, cend_cur, new_slot;
  logic [10:0]   score;
  logic          better, keep;
  logic [5:0]    weight_raw;
  logic [5:0]    weight;
  logic [31:0]   ticks_inc;
  logic [4:0]    tgt_prio;

  assign scan_next = ((CW'(scan_q) + CW'(1)) == n_q) ? '0 : scan_q + IW'(1);
  assign start_pos = ((CW'(cur_q) + CW'(1)) == n_q) ? '0 : cur_q + IW'(1);
  assign score     = {6'd0, eff_q[scan_q]} + (rt_q[scan_q] ? RtBonus : 11'd0);
  assign better    = !bestv_q || (vr_q[scan_q] < bestvr_q) ||
                     ((vr_q[scan_q] == bestvr_q) && (score > bestsc_q));
  assign keep      = (st_q[idx_i] != RS_DEAD) || (idx_i == run_q);
  assign cend_cur  = ncurv_q ? ncur_q : '0;
  assign new_slot  = n_q[IW-1:0];
  assign weight_raw = WeightBase - {1'b0, eff_q[run_q]};
  // Realtime tasks are charged a quarter of the weight, never less than one.
  assign weight     = rt_q[run_q] ? ((weight_raw > RtDivisor) ? (weight_raw >> 2) : 6'd1)
                                  : weight_raw;
  assign ticks_inc  = ticks_q[run_q] + 32'd1;

  // Effective priority of the target once the command has been applied.
  always_comb begin
    tgt_prio = eff_q[t_q];
    case (kind_q)
      KIND_PRIO: begin
        if (!boost_q[t_q]) begin
          tgt_prio = req_q;
        end
      end
      KIND_BOOST: begin
        if (eff_q[t_q] < req_q) begin
          tgt_prio = req_q;
        end
      end
      KIND_RESTORE: tgt_prio = base_q[t_q];
      default: ;
    endcase
  end

  assign status_o.resched = flag_q;
  assign status_o.hit     = (tid_q[idx_i] == tid_in_q);
  assign status_o.kind    = kind_q;
  assign count_o          = n_q;

  assign current_id_o      = tid_q[run_q];
  assign result_id_o       = newid_q;
  assign ok_o              = ok_q;
  assign switched_o        = moved_q;
  assign resched_pending_o = flag_q;
  assign target_priority_o = tprio_q;
  assign tick_total_o      = tick_q;
  assign switch_total_o    = sw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        tid_q[i]   <= (i == 0) ? 32'd1 : 32'd0;
        st_q[i]    <= (i == 0) ? RS_RUNNING : RS_READY;
        base_q[i]  <= PrioDefault;
        eff_q[i]   <= PrioDefault;
        ticks_q[i] <= '0;
        vr_q[i]    <= '0;
      end
      used_q    <= MAX_TASKS'(1);
      rt_q      <= '0;
      boost_q   <= '0;
      kind_q    <= '0;
      tid_in_q  <= '0;
      req_q     <= '0;
      rtreq_q   <= 1'b0;
      run_q     <= '0;
      cur_q     <= '0;
      scan_q    <= '0;
      best_q    <= '0;
      t_q       <= '0;
      nrun_q    <= '0;
      ncur_q    <= '0;
      bestv_q   <= 1'b0;
      ncurv_q   <= 1'b0;
      found_q   <= 1'b0;
      bestvr_q  <= '0;
      bestsc_q  <= '0;
      n_q       <= CW'(1);
      w_q       <= '0;
      nid_q     <= FirstNewId;
      quant_q   <= QuantumDef;
      tick_q    <= '0;
      sw_q      <= '0;
      flag_q    <= 1'b0;
      ok_q      <= 1'b0;
      moved_q   <= 1'b0;
      tprio_q   <= '0;
      newid_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        quant_q <= (cfg_data_i == 32'd0) ? 32'd1 : cfg_data_i;
      end
      case (op_i)
        OP_LOAD: begin
          kind_q   <= kind_i;
          tid_in_q <= task_id_i;
          req_q    <= clamp_prio(priority_req_i);
          rtreq_q  <= realtime_req_i;
          ok_q     <= 1'b1;
          moved_q  <= 1'b0;
          tprio_q  <= '0;
          newid_q  <= '0;
          found_q  <= 1'b0;
        end
        OP_PREP: begin
          if (kind_q == KIND_EXIT) begin
            st_q[run_q] <= RS_DEAD;
          end else if (st_q[run_q] == RS_RUNNING) begin
            st_q[run_q] <= RS_READY;
          end
          bestv_q <= 1'b0;
          scan_q  <= start_pos;
        end
        OP_PICK: begin
          if (st_q[scan_q] == RS_READY && better) begin
            bestv_q  <= 1'b1;
            best_q   <= scan_q;
            bestvr_q <= vr_q[scan_q];
            bestsc_q <= score;
          end
          scan_q <= scan_next;
        end
        OP_FIN: begin
          if (!bestv_q) begin
            if (st_q[run_q] == RS_READY) begin
              st_q[run_q]    <= RS_RUNNING;
              ticks_q[run_q] <= '0;
            end
          end else begin
            st_q[best_q]    <= RS_RUNNING;
            ticks_q[best_q] <= '0;
            run_q           <= best_q;
            cur_q           <= best_q;
            if (best_q != run_q) begin
              sw_q    <= sw_q + 64'd1;
              moved_q <= 1'b1;
            end
          end
          flag_q  <= 1'b0;
          w_q     <= '0;
          ncurv_q <= 1'b0;
          nrun_q  <= '0;
        end
        OP_CMP: begin
          // Live slots slide down over freed ones; w never passes the read index.
          if (keep) begin
            tid_q[w_q[IW-1:0]]   <= tid_q[idx_i];
            st_q[w_q[IW-1:0]]    <= st_q[idx_i];
            rt_q[w_q[IW-1:0]]    <= rt_q[idx_i];
            base_q[w_q[IW-1:0]]  <= base_q[idx_i];
            eff_q[w_q[IW-1:0]]   <= eff_q[idx_i];
            boost_q[w_q[IW-1:0]] <= boost_q[idx_i];
            ticks_q[w_q[IW-1:0]] <= ticks_q[idx_i];
            vr_q[w_q[IW-1:0]]    <= vr_q[idx_i];
            if (idx_i == run_q) begin
              nrun_q <= w_q[IW-1:0];
            end
            if (idx_i == cur_q) begin
              ncur_q  <= w_q[IW-1:0];
              ncurv_q <= 1'b1;
            end
            w_q <= w_q + CW'(1);
          end
        end
        OP_CEND: begin
          for (int j = 0; j < MAX_TASKS; j++) begin
            used_q[j] <= (CW'(j) < w_q);
          end
          n_q   <= w_q;
          run_q <= nrun_q;
          cur_q <= (st_q[cend_cur] == RS_DEAD) ? '0 : cend_cur;
        end
        OP_FIND: begin
          if (status_o.hit && !found_q) begin
            found_q <= 1'b1;
            t_q     <= idx_i;
          end
        end
        OP_APPLY: begin
          case (kind_q)
            KIND_TICK: begin
              tick_q <= tick_q + 64'd1;
              if (st_q[run_q] == RS_RUNNING) begin
                ticks_q[run_q] <= ticks_inc;
                vr_q[run_q]    <= vr_q[run_q] + {58'd0, weight};
                if (ticks_inc >= quant_q) begin
                  flag_q <= 1'b1;
                end
              end else if (ticks_q[run_q] >= quant_q) begin
                flag_q <= 1'b1;
              end
            end
            KIND_YIELD, KIND_YIELD_P, KIND_EXIT: begin
              ok_q <= 1'b1;
            end
            KIND_CREATE: begin
              if (n_q >= CW'(MAX_TASKS)) begin
                ok_q <= 1'b0;
              end else begin
                used_q[new_slot]  <= 1'b1;
                tid_q[new_slot]   <= nid_q;
                st_q[new_slot]    <= RS_READY;
                rt_q[new_slot]    <= 1'b0;
                base_q[new_slot]  <= PrioDefault;
                eff_q[new_slot]   <= PrioDefault;
                boost_q[new_slot] <= 1'b0;
                ticks_q[new_slot] <= '0;
                vr_q[new_slot]    <= vr_q[run_q];
                newid_q           <= nid_q;
                nid_q             <= nid_q + 32'd1;
                n_q               <= n_q + CW'(1);
                tprio_q           <= PrioDefault;
              end
            end
            KIND_KILL, KIND_PRIO, KIND_RT, KIND_BOOST, KIND_RESTORE: begin
              if (!found_q) begin
                ok_q <= 1'b0;
              end else begin
                tprio_q <= tgt_prio;
                case (kind_q)
                  KIND_KILL: begin
                    if (t_q == run_q) begin
                      ok_q <= 1'b0;
                    end else begin
                      st_q[t_q] <= RS_DEAD;
                      flag_q    <= 1'b1;
                    end
                  end
                  KIND_PRIO: begin
                    base_q[t_q] <= req_q;
                    if (!boost_q[t_q]) begin
                      eff_q[t_q] <= req_q;
                    end
                  end
                  KIND_RT: rt_q[t_q] <= rtreq_q;
                  KIND_BOOST: begin
                    if (eff_q[t_q] < req_q) begin
                      eff_q[t_q]   <= req_q;
                      boost_q[t_q] <= 1'b1;
                    end
                  end
                  default: begin
                    eff_q[t_q]   <= base_q[t_q];
                    boost_q[t_q] <= 1'b0;
                  end
                endcase
              end
            end
            default: ok_q <= 1'b0;
          endcase
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q != '0) && (n_q <= CW'(MAX_TASKS)))
    else $error("slot count out of range");
  a_run_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(run_q) < n_q))
    else $error("running slot outside used table");
  a_used_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_CEND) |=> (n_q == CW'($countones(used_q))))
    else $error("used slots do not match count after compaction");
  a_switch_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i != OP_FIN) |=> (sw_q == $past(sw_q)))
    else $error("switch counter moved outside a yield");
`endif

endmodule

// ===== rtl/core/vruntime_task_scheduler_core.sv =====
// Weighted virtual-runtime task scheduler.
// Command channel: a command beat is taken at a clock edge with start_i high
// and busy_o low; kind_i, task_id_i, priority_req_i and realtime_req_i carry
// it. Each command gives exactly one result beat, shown for one cycle while
// done_o is high; the receiver cannot stall, so it must take the beat then.
// Config channel: cfg_data_i is written into the quantum register on a
// cfg_valid_i / cfg_ready_o beat; cfg_ready_o is always high. Write it only
// while busy_o is low.
// Controller states between decode and done_o, with n used slots:
//   tick, create, unknown kinds, yield-if-pending without a request: apply;
//   kill, priority, class, boost, restore: id search over up to n slots, apply;
//   yield, exit, yield-if-pending with a request: prep, then one slot per
//   cycle through the pick scan, fin, one slot per cycle of compaction, cend.
// busy_o falls the cycle after done_o, so a new command may start then.
// Reset leaves task 1 running in slot 0, quantum 10, counters at zero.
module vruntime_task_scheduler_core
  import vrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasksDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [3:0]        kind_i,
  input  logic [31:0]       task_id_i,
  input  logic signed [6:0] priority_req_i,
  input  logic              realtime_req_i,
  output logic              done_o,
  output logic [31:0]       current_id_o,
  output logic [31:0]       result_id_o,
  output logic              ok_o,
  output logic              switched_o,
  output logic              resched_pending_o,
  output logic [4:0]        target_priority_o,
  output logic [63:0]       tick_total_o,
  output logic [63:0]       switch_total_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned IW = $clog2(MAX_TASKS);

  dp_op_e        op;
  logic [IW-1:0] idx;
  dp_status_t    status;
  logic [CW-1:0] count;

  assign cfg_ready_o = 1'b1;

  vrts_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .count_i  (count),
    .op_o     (op),
    .idx_o    (idx),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  vrts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .idx_i             (idx),
    .status_o          (status),
    .count_o           (count),
    .kind_i            (kind_i),
    .task_id_i         (task_id_i),
    .priority_req_i    (priority_req_i),
    .realtime_req_i    (realtime_req_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .current_id_o      (current_id_o),
    .result_id_o       (result_id_o),
    .ok_o              (ok_o),
    .switched_o        (switched_o),
    .resched_pending_o (resched_pending_o),
    .target_priority_o (target_priority_o),
    .tick_total_o      (tick_total_o),
    .switch_total_o    (switch_total_o)
  );

endmodule

// ===== tb/vruntime_task_scheduler_core_test.sv =====
module vruntime_task_scheduler_core_test;
  import vrts_pkg::*;

  localparam int NumSlots = 16;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic [31:0] current_id;
    logic [31:0] result_id;
    logic        ok;
    logic        switched;
    logic        resched_pending;
    logic [4:0]  target_priority;
    logic [63:0] tick_total;
    logic [63:0] switch_total;
  } sched_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [3:0]        kind_i = '0;
  logic [31:0]       task_id_i = '0;
  logic signed [6:0] priority_req_i = '0;
  logic              realtime_req_i = 1'b0;
  logic              done_o;
  logic [31:0]       current_id_o;
  logic [31:0]       result_id_o;
  logic              ok_o;
  logic              switched_o;
  logic              resched_pending_o;
  logic [4:0]        target_priority_o;
  logic [63:0]       tick_total_o;
  logic [63:0]       switch_total_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [31:0]       cfg_data_i = '0;

  vruntime_task_scheduler_core uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the task table.
  logic         sh_used [NumSlots];
  logic [31:0]  sh_id [NumSlots];
  run_state_e   sh_state [NumSlots];
  logic         sh_rt [NumSlots];
  logic [4:0]   sh_base [NumSlots];
  logic [4:0]   sh_eff [NumSlots];
  logic         sh_boosted [NumSlots];
  logic [31:0]  sh_ticks [NumSlots];
  logic [63:0]  sh_vrt [NumSlots];
  int           sh_run;
  int           sh_cursor;
  logic [31:0]  sh_next_id;
  logic [63:0]  sh_tick_count;
  logic [63:0]  sh_switch_count;
  logic         sh_resched;
  logic [31:0]  sh_quantum;

  sched_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;

  function automatic void wipe_slot(int s);
    sh_used[s] = 1'b0;
    sh_id[s] = '0;
    sh_state[s] = RS_READY;
    sh_rt[s] = 1'b0;
    sh_base[s] = PrioDefault;
    sh_eff[s] = PrioDefault;
    sh_boosted[s] = 1'b0;
    sh_ticks[s] = '0;
    sh_vrt[s] = '0;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NumSlots; i++) wipe_slot(i);
    sh_used[0] = 1'b1;
    sh_id[0] = 32'd1;
    sh_state[0] = RS_RUNNING;
    sh_run = 0;
    sh_cursor = 0;
    sh_next_id = 32'd2;
    sh_tick_count = '0;
    sh_switch_count = '0;
    sh_resched = 1'b0;
    sh_quantum = 32'd10;
  endfunction

  function automatic int live_slots();
    int n;
    n = 0;
    while (n < NumSlots && sh_used[n]) n++;
    return n;
  endfunction

  function automatic int slot_of(logic [31:0] id);
    int n;
    n = live_slots();
    for (int i = 0; i < n; i++) if (sh_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void copy_slot(int d, int s);
    sh_used[d] = sh_used[s];
    sh_id[d] = sh_id[s];
    sh_state[d] = sh_state[s];
    sh_rt[d] = sh_rt[s];
    sh_base[d] = sh_base[s];
    sh_eff[d] = sh_eff[s];
    sh_boosted[d] = sh_boosted[s];
    sh_ticks[d] = sh_ticks[s];
    sh_vrt[d] = sh_vrt[s];
  endfunction

  function automatic void reap_dead();
    int n, w, new_run, new_cur;
    n = live_slots();
    w = 0;
    new_run = 0;
    new_cur = -1;
    for (int i = 0; i < n; i++) begin
      if (sh_state[i] != RS_DEAD || i == sh_run) begin
        if (w != i) copy_slot(w, i);
        if (i == sh_run) new_run = w;
        if (i == sh_cursor) new_cur = w;
        w++;
      end
    end
    for (int i = w; i < NumSlots; i++) wipe_slot(i);
    sh_run = new_run;
    sh_cursor = (new_cur < 0) ? 0 : new_cur;
    if (sh_state[sh_cursor] == RS_DEAD) sh_cursor = 0;
  endfunction

  // Least virtual runtime wins; ties go to the higher score.
  function automatic int choose_ready();
    int n, first, idx, best, top_score, score;
    n = live_slots();
    best = -1;
    top_score = 0;
    if (n == 0) return -1;
    first = (sh_cursor % n + 1) % n;
    for (int k = 0; k < n; k++) begin
      idx = (first + k) % n;
      if (sh_state[idx] != RS_READY) continue;
      score = int'(sh_eff[idx]) + (sh_rt[idx] ? 1000 : 0);
      if (best < 0 || sh_vrt[idx] < sh_vrt[best] ||
          (sh_vrt[idx] == sh_vrt[best] && score > top_score)) begin
        best = idx;
        top_score = score;
      end
    end
    if (best >= 0) sh_cursor = best;
    return best;
  endfunction

  function automatic logic reschedule();
    int prev, nx;
    logic moved;
    prev = sh_run;
    moved = 1'b0;
    if (sh_state[prev] == RS_RUNNING) sh_state[prev] = RS_READY;
    nx = choose_ready();
    if (nx < 0) begin
      if (sh_state[prev] == RS_READY) begin
        sh_state[prev] = RS_RUNNING;
        sh_ticks[prev] = '0;
      end
    end else begin
      sh_state[nx] = RS_RUNNING;
      sh_ticks[nx] = '0;
      sh_run = nx;
      if (nx != prev) begin
        sh_switch_count++;
        moved = 1'b1;
      end
    end
    sh_resched = 1'b0;
    reap_dead();
    return moved;
  endfunction

  function automatic sched_result_t schedule_command(logic [3:0] k, logic [31:0] id,
                                                     logic signed [6:0] praw, logic rt);
    sched_result_t r;
    logic [4:0] req;
    logic [31:0] w;
    int t, n;
    r = '0;
    r.ok = 1'b1;
    req = (praw < 0) ? 5'd0 : (praw > 31) ? 5'd31 : praw[4:0];
    case (k)
      KIND_TICK: begin
        sh_tick_count++;
        if (sh_state[sh_run] == RS_RUNNING) begin
          sh_ticks[sh_run]++;
          w = 32'd40 - sh_eff[sh_run];
          if (sh_rt[sh_run]) w = (w > 4) ? w / 4 : 32'd1;
          sh_vrt[sh_run] += w;
        end
        if (sh_ticks[sh_run] >= sh_quantum) sh_resched = 1'b1;
      end
      KIND_YIELD: r.switched = reschedule();
      KIND_YIELD_P: if (sh_resched) r.switched = reschedule();
      KIND_CREATE: begin
        n = live_slots();
        if (n >= NumSlots) begin
          r.ok = 1'b0;
        end else begin
          wipe_slot(n);
          sh_used[n] = 1'b1;
          sh_id[n] = sh_next_id;
          sh_vrt[n] = sh_vrt[sh_run];
          r.result_id = sh_next_id;
          sh_next_id++;
          r.target_priority = sh_eff[n];
        end
      end
      KIND_EXIT: begin
        sh_state[sh_run] = RS_DEAD;
        r.switched = reschedule();
      end
      KIND_KILL, KIND_PRIO, KIND_RT, KIND_BOOST, KIND_RESTORE: begin
        t = slot_of(id);
        if (t < 0) begin
          r.ok = 1'b0;
        end else begin
          case (k)
            KIND_KILL: begin
              if (t == sh_run) begin
                r.ok = 1'b0;
              end else begin
                sh_state[t] = RS_DEAD;
                sh_resched = 1'b1;
              end
            end
            KIND_PRIO: begin
              sh_base[t] = req;
              if (!sh_boosted[t]) sh_eff[t] = req;
            end
            KIND_RT: sh_rt[t] = rt;
            KIND_BOOST: begin
              if (sh_eff[t] < req) begin
                sh_eff[t] = req;
                sh_boosted[t] = 1'b1;
              end
            end
            default: begin
              sh_eff[t] = sh_base[t];
              sh_boosted[t] = 1'b0;
            end
          endcase
          r.target_priority = sh_eff[t];
        end
      end
      default: r.ok = 1'b0;
    endcase
    r.current_id = sh_id[sh_run];
    r.resched_pending = sh_resched;
    r.tick_total = sh_tick_count;
    r.switch_total = sh_switch_count;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge that takes the beat.
  task automatic issue(logic [3:0] k, logic [31:0] id, logic signed [6:0] p, logic rt);
    start_i <= 1'b1;
    kind_i <= k;
    task_id_i <= id;
    priority_req_i <= p;
    realtime_req_i <= rt;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    pending_results.push_back(schedule_command(k, id, p, rt));
  endtask

  // Burst pacing of the command side.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_quantum(logic [31:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sh_quantum = (v == 0) ? 32'd1 : v;
  endtask

  always @(negedge clk_i) begin
    sched_result_t got, want;
    if (rst_ni && done_o) begin
      got = {current_id_o, result_id_o, ok_o, switched_o, resched_pending_o,
             target_priority_o, tick_total_o, switch_total_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: cur %h/%h rid %h/%h ok %b/%b sw %b/%b rp %b/%b ",
                      "prio %0d/%0d ticks %0d/%0d sw# %0d/%0d (exp/got)"},
                     want.current_id, got.current_id, want.result_id, got.result_id,
                     want.ok, got.ok, want.switched, got.switched,
                     want.resched_pending, got.resched_pending,
                     want.target_priority, got.target_priority,
                     want.tick_total, got.tick_total, want.switch_total, got.switch_total);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] some_id();
    int n;
    n = live_slots();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 40);
      default: return sh_id[$urandom_range(0, n - 1)];
    endcase
  endfunction

  task automatic test_directed();
    issue(KIND_TICK, 32'd0, 7'sd0, 1'b0); pace();
    issue(KIND_CREATE, 32'd0, 7'sd0, 1'b0); pace();
    issue(KIND_CREATE, 32'hFFFF_FFFF, -7'sd1, 1'b1); pace();
    issue(KIND_PRIO, 32'd2, -7'sd64, 1'b0); pace();
    issue(KIND_PRIO, 32'd2, 7'sd63, 1'b0); pace();
    issue(KIND_PRIO, 32'd3, 7'sd32, 1'b0); pace();
    issue(KIND_PRIO, 32'd3, 7'sd5, 1'b0); pace();
    issue(KIND_BOOST, 32'd3, 7'sd20, 1'b0); pace();
    issue(KIND_BOOST, 32'd3, 7'sd10, 1'b0); pace();
    issue(KIND_PRIO, 32'd3, 7'sd8, 1'b0); pace();
    issue(KIND_RESTORE, 32'd3, 7'sd0, 1'b0); pace();
    issue(KIND_RT, 32'd2, 7'sd0, 1'b1); pace();
    issue(KIND_TICK, 32'd0, 7'sd0, 1'b0); pace();
    issue(KIND_YIELD_P, 32'd0, 7'sd0, 1'b0); pace();
    issue(KIND_YIELD, 32'd0, 7'sd0, 1'b0); pace();
    issue(KIND_TICK, 32'd0, 7'sd0, 1'b0); pace();
    issue(KIND_KILL, sh_id[sh_run], 7'sd0, 1'b0); pace();
    issue(KIND_KILL, 32'hFFFF_FFFF, 7'sd0, 1'b0); pace();
    issue(KIND_KILL, 32'd1, 7'sd0, 1'b0); pace();
    issue(KIND_BOOST, 32'd1, 7'sd31, 1'b0); pace();
    issue(KIND_YIELD_P, 32'd0, 7'sd0, 1'b0); pace();
    issue(4'd10, 32'd0, 7'sd0, 1'b0); pace();
    issue(4'd15, 32'hFFFF_FFFF, 7'sd63, 1'b1); pace();
    issue(KIND_EXIT, 32'd0, 7'sd0, 1'b0); pace();
    // Lone task exits: nothing is ready, so the dead task stays current.
    issue(KIND_EXIT, 32'd0, 7'sd0, 1'b0); pace();
    issue(KIND_TICK, 32'd0, 7'sd0, 1'b0); pace();
  endtask

  task automatic test_quantum_one();
    set_quantum(32'd0);
    repeat (3) begin
      issue(KIND_CREATE, 32'd0, 7'sd0, 1'b0); pace();
      issue(KIND_TICK, 32'd0, 7'sd0, 1'b0); pace();
      issue(KIND_YIELD_P, 32'd0, 7'sd0, 1'b0); pace();
    end
  endtask

  task automatic test_table_full();
    repeat (NumSlots + 1) begin
      issue(KIND_CREATE, 32'd0, 7'sd0, 1'b0); pace();
    end
    issue(KIND_YIELD, 32'd0, 7'sd0, 1'b0); pace();
  endtask

  task automatic test_random(int count);
    logic [3:0] k;
    int sel;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) k = KIND_TICK;
      else if (sel < 40) k = KIND_YIELD;
      else if (sel < 50) k = KIND_YIELD_P;
      else if (sel < 62) k = KIND_CREATE;
      else if (sel < 69) k = KIND_KILL;
      else if (sel < 72) k = KIND_EXIT;
      else if (sel < 79) k = KIND_PRIO;
      else if (sel < 85) k = KIND_RT;
      else if (sel < 91) k = KIND_BOOST;
      else if (sel < 97) k = KIND_RESTORE;
      else k = 4'($urandom_range(10, 15));
      issue(k, some_id(), 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      pace();
    end
  endtask

  initial begin
    shadow_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_quantum_one();
    test_table_full();
    set_quantum(32'd3);
    test_random(400);
    // Command side holds off until every outstanding result is back.
    set_quantum(32'hFFFF_FFFF);
    test_random(300);
    set_quantum(32'd1);
    test_random(250);
    set_quantum(32'd10);
    test_random(250);
    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
